FILE: sv/tops_pkg.sv
// Package of the timed output pulse table: sizes, operation and status codes,
// the command and table entry types, and the sequencer state type.
// Depends on nothing; the front end, queue, back end, top and testbench import it.
`default_nettype none

package tops_pkg;

    localparam int SLOTS       = 8;
    localparam int SYSTEMS     = 4;
    localparam int MCODE_LIMIT = 100;
    localparam int MAX_WRITES  = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int SYS_W   = (SYSTEMS > 1) ? $clog2(SYSTEMS) : 1;
    localparam int ENTRIES = SYSTEMS * SLOTS;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WR_W    = $clog2(MAX_WRITES + 1);
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [9:0] MCODE_IO_SET = 10'd999;

    localparam logic [1:0] OP_BLOCK  = 2'd0;
    localparam logic [1:0] OP_POLL   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic [1:0] ALARM_INVALID  = 2'b01;
    localparam logic [1:0] ALARM_OVERFLOW = 2'b10;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_OVERFLOW
    } tops_status_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INVALID,
        CMD_STORE,
        CMD_POLL,
        CMD_CANCEL,
        CMD_IGNORE
    } tops_cmd_kind_t;

    typedef struct packed {
        tops_cmd_kind_t    kind;
        logic [SYS_W-1:0]  sys;
        logic [7:0]        port;
        logic [31:0]       level;
        logic [31:0]       mask;
        logic [31:0]       duration;
        logic [31:0]       now;
    } tops_cmd_t;

    typedef struct packed {
        logic      valid;
        tops_cmd_t cmd;
    } tops_push_t;

    typedef struct packed {
        logic [7:0]  port;
        logic [31:0] level;
        logic [31:0] mask;
        logic [31:0] duration;
        logic [31:0] start;
    } tops_entry_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_SCAN,
        BS_EVAL,
        BS_DONE
    } tops_bstate_t;

endpackage

`default_nettype wire

FILE: sv/tops_if.sv
// Channel interfaces of the timed output pulse table: the request channel
// and the result channel, each with valid, ready and payload.
// Depends on nothing.
`default_nettype none

interface tops_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [1:0]  system;
    logic [9:0]  mcode;
    logic        post_action;
    logic [7:0]  port;
    logic [31:0] level;
    logic [31:0] bit_mask;
    logic [31:0] duration;
    logic [31:0] now;

    modport source (output valid, operation, system, mcode, post_action, port, level,
                    bit_mask, duration, now, input ready);
    modport sink (input valid, operation, system, mcode, post_action, port, level,
                  bit_mask, duration, now, output ready);
endinterface

interface tops_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  out_port;
    logic [31:0] out_level;
    logic [31:0] out_mask;
    logic [1:0]  alarms;
    logic        last;

    modport source (output valid, kind, status, out_port, out_level, out_mask, alarms,
                    last, input ready);
    modport sink (input valid, kind, status, out_port, out_level, out_mask, alarms,
                  last, output ready);
endinterface

`default_nettype wire

FILE: sv/tops_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module tops_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/tops_front.sv
// Front end of the timed output pulse table: takes requests and classifies
// them into commands for the back end. Depends on tops_pkg and tops_if.
`default_nettype none

module tops_front
    import tops_pkg::*;
(
    tops_item_if.sink        items,
    input  wire logic        full,
    output tops_push_t       push
);

    tops_cmd_kind_t kind;
    logic           sys_ok;

    assign sys_ok = (32'(items.system) < 32'(SYSTEMS));

    always_comb
    begin
        kind = CMD_NONE;
        if (!sys_ok)
        begin
            kind = CMD_IGNORE;
        end
        else
        begin
            unique case (items.operation)
                OP_BLOCK:
                begin
                    // Code zero is a block without an M code.
                    if (items.mcode == 10'd0)
                    begin
                        kind = CMD_NONE;
                    end
                    else if (items.mcode >= 10'(MCODE_LIMIT) && items.mcode != MCODE_IO_SET)
                    begin
                        kind = CMD_INVALID;
                    end
                    else if (items.post_action && items.mcode == MCODE_IO_SET)
                    begin
                        kind = CMD_STORE;
                    end
                end
                OP_POLL:   kind = CMD_POLL;
                OP_CANCEL: kind = CMD_CANCEL;
                default:   kind = CMD_NONE;
            endcase
        end
    end

    assign items.ready       = !full;
    assign push.valid        = items.valid && !full;
    assign push.cmd.kind     = kind;
    assign push.cmd.sys      = SYS_W'(items.system);
    assign push.cmd.port     = items.port;
    assign push.cmd.level    = items.level;
    assign push.cmd.mask     = items.bit_mask;
    assign push.cmd.duration = items.duration;
    assign push.cmd.now      = items.now;

endmodule

`default_nettype wire

FILE: sv/tops_queue.sv
// Short command queue between the front end and the back end.
// Depends on tops_pkg.
`default_nettype none

module tops_queue
    import tops_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tops_push_t push,
    output logic            full,
    output tops_push_t      head,
    input  wire logic       pop
);

    tops_cmd_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push.valid && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

FILE: sv/tops_back.sv
// Back end of the timed output pulse table: the slot tables, the job RAM,
// the sequencer that walks the slots and the result register.
// Depends on tops_pkg, tops_if and tops_ram.
`default_nettype none

module tops_back
    import tops_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tops_push_t head,
    output logic            pop,
    tops_result_if.source   results
);

    tops_bstate_t state_reg;
    tops_bstate_t state_next;
    tops_cmd_t    cmd_reg;
    logic         cmd_load;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [WR_W-1:0]  nwr_reg;
    logic [WR_W-1:0]  nwr_next;
    tops_status_t status_reg;
    tops_status_t status_next;

    logic [SYSTEMS-1:0][SLOTS-1:0] valid_reg;
    logic [SYSTEMS-1:0][SLOTS-1:0] valid_next;
    logic [SYSTEMS-1:0][SLOTS-1:0] wait_reg;
    logic [SYSTEMS-1:0][SLOTS-1:0] wait_next;
    logic [SYSTEMS-1:0][CNT_W-1:0] count_reg;
    logic [SYSTEMS-1:0][CNT_W-1:0] count_next;
    logic [SYSTEMS-1:0][1:0]       alarm_reg;
    logic [SYSTEMS-1:0][1:0]       alarm_next;

    logic        ovalid_reg;
    logic        o_kind_reg;
    logic        o_kind_next;
    logic [1:0]  o_status_reg;
    logic [1:0]  o_status_next;
    logic [7:0]  o_port_reg;
    logic [7:0]  o_port_next;
    logic [31:0] o_level_reg;
    logic [31:0] o_level_next;
    logic [31:0] o_mask_reg;
    logic [31:0] o_mask_next;
    logic [1:0]  o_alarms_reg;
    logic [1:0]  o_alarms_next;
    logic        o_last_reg;
    logic        o_last_next;
    logic        out_load;
    logic        out_free;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    tops_entry_t       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    tops_entry_t       ram_rdata;

    logic [SYS_W-1:0]  hsys;
    logic [SYS_W-1:0]  csys;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] free_idx;
    logic              cur_valid;
    logic              cur_wait;
    logic              scan_end;
    logic [31:0]       elapsed;
    logic              expired;

    function automatic logic [SLOT_W-1:0] first_free(input logic [SLOTS-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    assign hsys      = head.cmd.sys;
    assign csys      = cmd_reg.sys;
    assign slot      = idx_reg[SLOT_W-1:0];
    assign free_idx  = first_free(valid_reg[hsys]);
    assign cur_valid = valid_reg[csys][slot];
    assign cur_wait  = wait_reg[csys][slot];
    assign scan_end  = (idx_reg >= CNT_W'(SLOTS)) || (nwr_reg >= WR_W'(MAX_WRITES));
    assign elapsed   = cmd_reg.now - ram_rdata.start;
    assign expired   = (elapsed >= ram_rdata.duration);
    assign out_free  = !ovalid_reg || results.ready;
    assign ram_raddr = ADDR_W'(SLOTS) * ADDR_W'(csys) + ADDR_W'(slot);

    tops_ram #(
        .WIDTH ($bits(tops_entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = (head.cmd.kind == CMD_POLL) ? BS_SCAN : BS_DONE;
                end
            end
            BS_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = BS_DONE;
                end
                else if (cur_valid)
                begin
                    state_next = BS_EVAL;
                end
            end
            BS_EVAL:
            begin
                if (out_free)
                begin
                    state_next = BS_SCAN;
                end
            end
            BS_DONE:
            begin
                if (out_free)
                begin
                    state_next = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        cmd_load      = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = ram_raddr;
        ram_wdata     = ram_rdata;
        idx_next      = idx_reg;
        nwr_next      = nwr_reg;
        status_next   = status_reg;
        valid_next    = valid_reg;
        wait_next     = wait_reg;
        count_next    = count_reg;
        alarm_next    = alarm_reg;
        out_load      = 1'b0;
        o_kind_next   = KIND_WRITE;
        o_status_next = ST_OK;
        o_port_next   = ram_rdata.port;
        o_level_next  = ram_rdata.level & ram_rdata.mask;
        o_mask_next   = ram_rdata.mask;
        o_alarms_next = alarm_reg[csys];
        o_last_next   = 1'b0;

        unique case (state_reg)
            BS_IDLE:
            begin
                if (head.valid)
                begin
                    pop         = 1'b1;
                    cmd_load    = 1'b1;
                    idx_next    = '0;
                    nwr_next    = '0;
                    status_next = ST_OK;
                    unique case (head.cmd.kind)
                        CMD_STORE:
                        begin
                            if (count_reg[hsys] >= CNT_W'(SLOTS))
                            begin
                                alarm_next[hsys] = alarm_reg[hsys] | ALARM_OVERFLOW;
                                status_next      = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we             = 1'b1;
                                ram_waddr          = ADDR_W'(SLOTS) * ADDR_W'(hsys)
                                                     + ADDR_W'(free_idx);
                                ram_wdata.port     = head.cmd.port;
                                ram_wdata.level    = head.cmd.level;
                                ram_wdata.mask     = head.cmd.mask;
                                ram_wdata.duration = head.cmd.duration;
                                ram_wdata.start    = '0;
                                valid_next[hsys][free_idx] = 1'b1;
                                wait_next[hsys][free_idx]  = 1'b0;
                                count_next[hsys] = count_reg[hsys] + 1'b1;
                            end
                        end
                        CMD_INVALID:
                        begin
                            alarm_next[hsys] = alarm_reg[hsys] | ALARM_INVALID;
                            status_next      = ST_INVALID;
                        end
                        CMD_CANCEL:
                        begin
                            valid_next[hsys] = '0;
                            wait_next[hsys]  = '0;
                            count_next[hsys] = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BS_SCAN:
            begin
                if (!scan_end)
                begin
                    if (cur_valid)
                    begin
                        ram_re = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            BS_EVAL:
            begin
                if (out_free)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (!cur_wait)
                    begin
                        out_load = 1'b1;
                        nwr_next = nwr_reg + 1'b1;
                        if (ram_rdata.duration != 32'd0)
                        begin
                            // Start timing: write the entry back with the poll's tick.
                            ram_we                = 1'b1;
                            ram_wdata.start       = cmd_reg.now;
                            wait_next[csys][slot] = 1'b1;
                        end
                        else
                        begin
                            valid_next[csys][slot] = 1'b0;
                            wait_next[csys][slot]  = 1'b0;
                            if (count_reg[csys] != '0)
                            begin
                                count_next[csys] = count_reg[csys] - 1'b1;
                            end
                        end
                    end
                    else if (expired)
                    begin
                        out_load     = 1'b1;
                        nwr_next     = nwr_reg + 1'b1;
                        o_level_next = ~ram_rdata.level & ram_rdata.mask;
                        valid_next[csys][slot] = 1'b0;
                        wait_next[csys][slot]  = 1'b0;
                        if (count_reg[csys] != '0)
                        begin
                            count_next[csys] = count_reg[csys] - 1'b1;
                        end
                    end
                end
            end
            BS_DONE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    o_kind_next   = KIND_STATUS;
                    o_status_next = status_reg;
                    o_port_next   = '0;
                    o_level_next  = '0;
                    o_mask_next   = '0;
                    o_alarms_next = (cmd_reg.kind == CMD_IGNORE) ? 2'b00 : alarm_reg[csys];
                    o_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BS_IDLE;
            idx_reg    <= '0;
            nwr_reg    <= '0;
            status_reg <= ST_OK;
            valid_reg  <= '0;
            wait_reg   <= '0;
            count_reg  <= '0;
            alarm_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            nwr_reg    <= nwr_next;
            status_reg <= status_next;
            valid_reg  <= valid_next;
            wait_reg   <= wait_next;
            count_reg  <= count_next;
            alarm_reg  <= alarm_next;
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_load)
        begin
            cmd_reg <= head.cmd;
        end
        if (out_load)
        begin
            o_kind_reg   <= o_kind_next;
            o_status_reg <= o_status_next;
            o_port_reg   <= o_port_next;
            o_level_reg  <= o_level_next;
            o_mask_reg   <= o_mask_next;
            o_alarms_reg <= o_alarms_next;
            o_last_reg   <= o_last_next;
        end
    end

    assign results.valid     = ovalid_reg;
    assign results.kind      = o_kind_reg;
    assign results.status    = o_status_reg;
    assign results.out_port  = o_port_reg;
    assign results.out_level = o_level_reg;
    assign results.out_mask  = o_mask_reg;
    assign results.alarms    = o_alarms_reg;
    assign results.last      = o_last_reg;

`ifndef SYNTH
    // The job count of the system in work tracks its valid slots.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BS_IDLE && cmd_reg.kind != CMD_IGNORE)
        |-> (32'(count_reg[csys]) == $countones(valid_reg[csys])))
        else $error("job count differs from number of valid slots");

    // Only a slot that holds a job is ever evaluated.
    a_eval_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_EVAL) |-> cur_valid)
        else $error("evaluating a free slot");

    // A poll never emits more writes than the budget.
    a_write_budget: assert property (@(posedge clk) disable iff (!rst_n)
        nwr_reg <= WR_W'(MAX_WRITES))
        else $error("write budget exceeded");

    // The slot walk stops at the end of the table.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= CNT_W'(SLOTS))
        else $error("slot index past the table");
`endif

endmodule

`default_nettype wire

FILE: sv/timed_output_pulse_table.sv
// Timed output pulse table. Each coordinate system keeps SLOTS pending output
// pulse jobs. Block requests with M999 in post-action position store a job,
// poll requests walk the system's slots and emit output writes, cancel requests
// drop all jobs of a system. Every request ends with one status result
// (last = 1), preceded by any output writes. Block, cancel and no-op requests
// go from idle straight to the done state of the back end; a poll walks the slots
// in the scan state, evaluating each occupied one from the job RAM, one slot at a
// time, until the slots or the write budget run out. A two-entry command
// queue lets requests be accepted while an earlier one is at work, and a result
// register lets the next result be formed while the current one waits.
// Depends on tops_pkg, tops_if, tops_front, tops_queue and tops_back.
`default_nettype none

module timed_output_pulse_table
    import tops_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tops_item_if.sink     items,
    tops_result_if.source results
);

    tops_push_t push;
    tops_push_t head;
    logic       q_full;
    logic       pop;

    tops_front u_front (
        .items (items),
        .full  (q_full),
        .push  (push)
    );

    tops_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    tops_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire

FILE: bench/tb_timed_output_pulse_table.sv
// Testbench of the timed output pulse table: a table of directed requests and then
// random job sequences, every result checked against a predictor of the pulse tables.
// Depends on tops_pkg, tops_if and timed_output_pulse_table.
`default_nettype none

module tb_timed_output_pulse_table;
    import tops_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         SETTLE      = 40;
    localparam int         PHASE_ITEMS = 32;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  sys;
        logic [9:0]  mcode;
        logic        post;
        logic [7:0]  port;
        logic [31:0] level;
        logic [31:0] mask;
        logic [31:0] duration;
        logic [31:0] now;
    } pulse_req_t;

    typedef struct packed {
        logic         kind;
        tops_status_t status;
        logic [7:0]   port;
        logic [31:0]  level;
        logic [31:0]  mask;
        logic [1:0]   alarms;
        logic         last;
    } pulse_res_t;

    typedef struct {
        logic        valid;
        logic        waiting;
        logic [7:0]  port;
        logic [31:0] level;
        logic [31:0] mask;
        logic [31:0] duration;
        logic [31:0] start;
    } pulse_job_t;

    typedef struct {
        pulse_req_t   req;
        bit           typed;
        tops_status_t want_status;
        logic [1:0]   want_alarms;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tops_item_if   items ();
    tops_result_if results ();

    timed_output_pulse_table uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    always #1 clk = ~clk;

    // Predicted state of the pulse tables.
    pulse_job_t  pulse_jobs [SYSTEMS][SLOTS];
    int unsigned job_total [SYSTEMS];
    logic [1:0]  sticky_alarms [SYSTEMS];

    pulse_res_t    awaited_results [$];
    directed_row_t directed_rows [$];

    logic [31:0] tick_count = 32'd0;
    int send_idle = 0;
    int recv_idle = 0;
    int stalled_cycles = 0;
    int mismatches = 0;
    int requests_sent = 0;
    int writes_seen = 0;
    int status_seen = 0;

    function automatic pulse_res_t make_result(input logic kind, input tops_status_t status,
                                               input logic [7:0] port, input logic [31:0] level,
                                               input logic [31:0] mask,
                                               input logic [1:0] alarms, input logic last);
        pulse_res_t r;
        r.kind   = kind;
        r.status = status;
        r.port   = port;
        r.level  = level;
        r.mask   = mask;
        r.alarms = alarms;
        r.last   = last;
        return r;
    endfunction

    function automatic void release_job(input int unsigned s, input int i);
        pulse_jobs[s][i].valid   = 1'b0;
        pulse_jobs[s][i].waiting = 1'b0;
        if (job_total[s] > 0)
            job_total[s]--;
    endfunction

    task automatic predict_pulse_table(input pulse_req_t r);
        int unsigned  s;
        int           n;
        tops_status_t st;
        logic [31:0]  elapsed;
        s  = r.sys;
        n  = 0;
        st = ST_OK;
        if (s >= SYSTEMS)
        begin
            awaited_results.push_back(make_result(KIND_STATUS, ST_OK, 8'd0, 32'd0, 32'd0,
                                                  2'b00, 1'b1));
            return;
        end
        case (r.op)
            OP_BLOCK:
            begin
                if (r.mcode == 10'd0)
                begin
                    st = ST_OK;
                end
                else if (r.mcode >= MCODE_LIMIT && r.mcode != MCODE_IO_SET)
                begin
                    sticky_alarms[s] |= ALARM_INVALID;
                    st = ST_INVALID;
                end
                else if (r.post && r.mcode == MCODE_IO_SET)
                begin
                    if (job_total[s] >= SLOTS)
                    begin
                        sticky_alarms[s] |= ALARM_OVERFLOW;
                        st = ST_OVERFLOW;
                    end
                    else
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (!pulse_jobs[s][i].valid)
                            begin
                                pulse_jobs[s][i].port     = r.port;
                                pulse_jobs[s][i].level    = r.level;
                                pulse_jobs[s][i].mask     = r.mask;
                                pulse_jobs[s][i].duration = r.duration;
                                pulse_jobs[s][i].start    = 32'd0;
                                pulse_jobs[s][i].waiting  = 1'b0;
                                pulse_jobs[s][i].valid    = 1'b1;
                                job_total[s]++;
                                break;
                            end
                        end
                    end
                end
            end
            OP_POLL:
            begin
                for (int i = 0; i < SLOTS && n < MAX_WRITES; i++)
                begin
                    if (!pulse_jobs[s][i].valid)
                        continue;
                    if (!pulse_jobs[s][i].waiting)
                    begin
                        awaited_results.push_back(make_result(KIND_WRITE, ST_OK,
                            pulse_jobs[s][i].port,
                            pulse_jobs[s][i].level & pulse_jobs[s][i].mask,
                            pulse_jobs[s][i].mask, sticky_alarms[s], 1'b0));
                        n++;
                        if (pulse_jobs[s][i].duration != 32'd0)
                        begin
                            pulse_jobs[s][i].start   = r.now;
                            pulse_jobs[s][i].waiting = 1'b1;
                        end
                        else
                        begin
                            release_job(s, i);
                        end
                    end
                    else
                    begin
                        // The elapsed time wraps at 32 bits, like the tick counter.
                        elapsed = r.now - pulse_jobs[s][i].start;
                        if (elapsed >= pulse_jobs[s][i].duration)
                        begin
                            awaited_results.push_back(make_result(KIND_WRITE, ST_OK,
                                pulse_jobs[s][i].port,
                                ~pulse_jobs[s][i].level & pulse_jobs[s][i].mask,
                                pulse_jobs[s][i].mask, sticky_alarms[s], 1'b0));
                            n++;
                            release_job(s, i);
                        end
                    end
                end
            end
            OP_CANCEL:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    pulse_jobs[s][i].valid   = 1'b0;
                    pulse_jobs[s][i].waiting = 1'b0;
                end
                job_total[s] = 0;
            end
            default:
            begin
            end
        endcase
        awaited_results.push_back(make_result(KIND_STATUS, st, 8'd0, 32'd0, 32'd0,
                                              sticky_alarms[s], 1'b1));
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    function automatic pulse_req_t make_req(input logic [1:0] op, input logic [1:0] sys,
                                            input logic [9:0] mcode, input logic post,
                                            input logic [7:0] port, input logic [31:0] level,
                                            input logic [31:0] mask,
                                            input logic [31:0] duration,
                                            input logic [31:0] now);
        pulse_req_t r;
        r.op       = op;
        r.sys      = sys;
        r.mcode    = mcode;
        r.post     = post;
        r.port     = port;
        r.level    = level;
        r.mask     = mask;
        r.duration = duration;
        r.now      = now;
        return r;
    endfunction

    function automatic void add_row(input pulse_req_t req, input bit typed,
                                    input tops_status_t want_status,
                                    input logic [1:0] want_alarms);
        directed_row_t row;
        row.req         = req;
        row.typed       = typed;
        row.want_status = want_status;
        row.want_alarms = want_alarms;
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed_rows();
        add_row(make_req(OP_POLL, 2'd0, 10'd0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0),
                1'b1, ST_OK, 2'b00);
        add_row(make_req(OP_BLOCK, 2'd0, 10'd0, 1'b1, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0),
                1'b1, ST_OK, 2'b00);
        add_row(make_req(OP_BLOCK, 2'd0, 10'd99, 1'b1, 8'd3, 32'd0, 32'd0, 32'd0, 32'd0),
                1'b1, ST_OK, 2'b00);
        add_row(make_req(OP_BLOCK, 2'd0, 10'd100, 1'b1, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0),
                1'b1, ST_INVALID, ALARM_INVALID);
        add_row(make_req(OP_BLOCK, 2'd0, 10'd1023, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0),
                1'b1, ST_INVALID, ALARM_INVALID);
        // M999 before the motion is accepted but stores nothing.
        add_row(make_req(OP_BLOCK, 2'd0, MCODE_IO_SET, 1'b0, 8'd7, '1, '1, 32'd4, 32'd0),
                1'b1, ST_OK, ALARM_INVALID);
        add_row(make_req(OP_BLOCK, 2'd0, MCODE_IO_SET, 1'b1, 8'hFF, '1, '1, 32'd0, 32'd0),
                1'b0, ST_OK, 2'b00);
        add_row(make_req(OP_BLOCK, 2'd0, MCODE_IO_SET, 1'b1, 8'h00, 32'd0, '1, '1, 32'd0),
                1'b0, ST_OK, 2'b00);
        add_row(make_req(OP_BLOCK, 2'd0, MCODE_IO_SET, 1'b1, 8'hA5, 32'h5A5A_F00F,
                         32'h0FF0_FF00, 32'd5, 32'd0), 1'b0, ST_OK, 2'b00);
        add_row(make_req(OP_POLL, 2'd0, 10'd0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFE),
                1'b0, ST_OK, 2'b00);
        // The tick counter wraps between start and this poll.
        add_row(make_req(OP_POLL, 2'd0, 10'd0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd3),
                1'b0, ST_OK, 2'b00);
        for (int i = 0; i < SLOTS; i++)
            add_row(make_req(OP_BLOCK, 2'd1, MCODE_IO_SET, 1'b1, 8'(i * 37 + 1),
                             32'h8000_0001 << i, 32'hFFFF_0F0F >> i, 32'(i % 2), 32'd0),
                    1'b0, ST_OK, 2'b00);
        add_row(make_req(OP_BLOCK, 2'd1, MCODE_IO_SET, 1'b1, 8'd9, '1, '1, 32'd1, 32'd0),
                1'b1, ST_OVERFLOW, ALARM_OVERFLOW);
        add_row(make_req(OP_POLL, 2'd1, 10'd0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd100),
                1'b0, ST_OK, 2'b00);
        add_row(make_req(OP_CANCEL, 2'd1, 10'd0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0),
                1'b1, ST_OK, ALARM_OVERFLOW);
        add_row(make_req(OP_POLL, 2'd1, 10'd0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd500),
                1'b1, ST_OK, ALARM_OVERFLOW);
        add_row(make_req(OP_UNUSED, 2'd2, 10'd100, 1'b1, 8'd1, '1, '1, 32'd1, 32'd1),
                1'b1, ST_OK, 2'b00);
        add_row(make_req(OP_POLL, 2'd0, 10'd0, 1'b0, 8'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFD),
                1'b0, ST_OK, 2'b00);
    endfunction

    function automatic pulse_req_t random_request();
        pulse_req_t r;
        int pick;
        int span;
        // Unused fields carry random values on every request.
        r.op       = 2'($urandom_range(3));
        r.sys      = 2'($urandom_range(3));
        r.mcode    = 10'($urandom_range(1023));
        r.post     = 1'($urandom_range(1));
        r.port     = 8'($urandom);
        r.level    = $urandom;
        r.mask     = $urandom;
        r.duration = $urandom;
        r.now      = $urandom;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            r.op    = OP_BLOCK;
            r.mcode = MCODE_IO_SET;
            r.post  = 1'b1;
            span    = $urandom_range(99);
            if (span < 25)
                r.duration = 32'd0;
            else if (span < 85)
                r.duration = 32'($urandom_range(30, 1));
        end
        else if (pick < 75)
        begin
            r.op = OP_POLL;
            if ($urandom_range(19) != 0)
                r.now = tick_count + 32'($urandom_range(15));
            tick_count = r.now;
        end
        else if (pick < 82)
        begin
            r.op = OP_BLOCK;
        end
        else if (pick < 87)
        begin
            r.op    = OP_BLOCK;
            r.mcode = MCODE_IO_SET;
            r.post  = 1'b0;
        end
        else if (pick < 92)
        begin
            r.op = OP_CANCEL;
        end
        else
        begin
            r.op = OP_UNUSED;
        end
        return r;
    endfunction

    // The valid line is left high after acceptance so that a following request
    // can go out back to back.
    task automatic send_request(input pulse_req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid       <= 1'b1;
        items.operation   <= r.op;
        items.system      <= r.sys;
        items.mcode       <= r.mcode;
        items.post_action <= r.post;
        items.port        <= r.port;
        items.level       <= r.level;
        items.bit_mask    <= r.mask;
        items.duration    <= r.duration;
        items.now         <= r.now;
        do
            @(posedge clk);
        while (!items.ready);
        predict_pulse_table(r);
        requests_sent++;
    endtask

    task automatic wait_results_drained();
        items.valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited_results.size() != 0);
        @(posedge clk);
    endtask

    always @(posedge clk)
        results.ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        pulse_res_t want;
        if (rst_n && results.valid && results.ready)
        begin
            if (results.kind == KIND_WRITE)
                writes_seen++;
            else
                status_seen++;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with nothing awaited, expected none, got kind %0h",
                         $time, results.kind);
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (results.kind !== want.kind)
                    flag_mismatch("kind", 32'(want.kind), 32'(results.kind));
                if (results.status !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(results.status));
                if (results.out_port !== want.port)
                    flag_mismatch("out_port", 32'(want.port), 32'(results.out_port));
                if (results.out_level !== want.level)
                    flag_mismatch("out_level", want.level, results.out_level);
                if (results.out_mask !== want.mask)
                    flag_mismatch("out_mask", want.mask, results.out_mask);
                if (results.alarms !== want.alarms)
                    flag_mismatch("alarms", 32'(want.alarms), 32'(results.alarms));
                if (results.last !== want.last)
                    flag_mismatch("last", 32'(want.last), 32'(results.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready))
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb_timed_output_pulse_table: errors");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial
    begin
        pulse_res_t got;
        rst_n             = 1'b0;
        items.valid       = 1'b0;
        items.operation   = OP_BLOCK;
        items.system      = 2'd0;
        items.mcode       = 10'd0;
        items.post_action = 1'b0;
        items.port        = 8'd0;
        items.level       = 32'd0;
        items.bit_mask    = 32'd0;
        items.duration    = 32'd0;
        items.now         = 32'd0;
        for (int s = 0; s < SYSTEMS; s++)
        begin
            job_total[s]     = 0;
            sticky_alarms[s] = 2'b00;
            for (int i = 0; i < SLOTS; i++)
            begin
                pulse_jobs[s][i].valid   = 1'b0;
                pulse_jobs[s][i].waiting = 1'b0;
            end
        end
        build_directed_rows();

        repeat (6) @(posedge clk);
        rst_n     <= 1'b1;
        send_idle  = 17;
        recv_idle <= 47;

        foreach (directed_rows[k])
        begin
            send_request(directed_rows[k].req);
            if (directed_rows[k].typed)
            begin
                got = awaited_results[$];
                if (got.status !== directed_rows[k].want_status)
                    flag_mismatch("directed status", 32'(directed_rows[k].want_status),
                                  32'(got.status));
                if (got.alarms !== directed_rows[k].want_alarms)
                    flag_mismatch("directed alarms", 32'(directed_rows[k].want_alarms),
                                  32'(got.alarms));
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase > 0)
            begin
                // Hold off until every result of the earlier requests is back.
                wait_results_drained();
                send_idle  = (phase == 1) ? 47 : 0;
                recv_idle <= (phase == 1) ? 17 : 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request());
        end

        wait_results_drained();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d requests, %0d of them directed, under three idle patterns",
                 requests_sent, directed_rows.size());
        $display("checked %0d output writes and %0d status results, %0d mismatches",
                 writes_seen, status_seen, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("tb_timed_output_pulse_table: clean");
        else
            $display("tb_timed_output_pulse_table: errors");
        $finish;
    end

endmodule

`default_nettype wire
